### sv/rhd_pkg.sv
// Shared types and constants of the RTP H.264 depacketizer.
// No dependencies; imported by every module of the block.
package rhd_pkg;

    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_ABORT   = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    localparam logic [1:0] CLS_DROP   = 2'd0;
    localparam logic [1:0] CLS_PASS   = 2'd1;
    localparam logic [1:0] CLS_FU_HDR = 2'd2;

    localparam logic [2:0] REG_AUDIO_PT   = 3'd0;
    localparam logic [2:0] REG_VIDEO_PT   = 3'd1;
    localparam logic [2:0] REG_AUDIO_EN   = 3'd2;
    localparam logic [2:0] REG_VIDEO_EN   = 3'd3;
    localparam logic [2:0] REG_AUDIO_RATE = 3'd4;
    localparam logic [2:0] REG_VIDEO_RATE = 3'd5;

    localparam logic [4:0] NAL_TYPE_MASK = 5'h1F;
    localparam logic [4:0] NAL_SLICE     = 5'h01;
    localparam logic [4:0] NAL_IDR       = 5'h05;
    localparam logic [4:0] NAL_SPS       = 5'h07;
    localparam logic [4:0] NAL_PPS       = 5'h08;
    localparam logic [4:0] NAL_FU_A      = 5'h1C;
    localparam logic [7:0] FU_NRI_MASK   = 8'hE0;

    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

    // which result the datapath loads into the output register
    typedef enum logic [4:0] {
        SEL_UNK   = 5'b00001,
        SEL_ABORT = 5'b00010,
        SEL_SC    = 5'b00100,
        SEL_BYTE  = 5'b01000,
        SEL_END   = 5'b10000
    } t_sel;

    // results one accepted byte causes, registered at accept
    typedef struct packed {
        logic unk;
        logic abort;
        logic sc;
        logic byte_en;
        logic fin;
    } t_plan;

    typedef struct packed {
        logic       accept;
        logic       emit;
        t_sel       sel;
        logic [1:0] sc_idx;
    } t_cmd;

    typedef struct packed {
        t_plan plan;
        logic  out_free;
        logic  div_done;
    } t_status;

    function automatic logic is_key_type(input logic [4:0] t);
        return (t == NAL_IDR) || (t == NAL_SPS) || (t == NAL_PPS);
    endfunction

endpackage

### sv/rhd_if.sv
// Channel interfaces of the depacketizer: input bytes, results, register writes.
// Depends on nothing.
interface rhd_in_if;
    logic        valid;
    logic        ready;
    logic [6:0]  payload_type;
    logic [7:0]  data_byte;
    logic        pkt_first;
    logic        pkt_last;
    logic        marker;
    logic [31:0] rtp_timestamp;
    modport source (output valid, payload_type, data_byte, pkt_first, pkt_last, marker,
                    rtp_timestamp, input ready);
    modport sink (input valid, payload_type, data_byte, pkt_first, pkt_last, marker,
                  rtp_timestamp, output ready);
endinterface

interface rhd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  out_byte;
    logic        is_video;
    logic        is_key;
    logic [23:0] frame_length;
    logic [31:0] stamp_sec;
    logic [19:0] stamp_usec;
    modport source (output valid, result_kind, out_byte, is_video, is_key, frame_length,
                    stamp_sec, stamp_usec, input ready);
    modport sink (input valid, result_kind, out_byte, is_video, is_key, frame_length,
                  stamp_sec, stamp_usec, output ready);
endinterface

interface rhd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### sv/rhd_div.sv
// Timestamp to seconds/microseconds converter: shared restoring divider.
// Uses rhd_pkg. sec = ts / rate, then usec = (rem * 1e6) / rate.
module rhd_div
    import rhd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_ts,
    input  logic [31:0] i_rate,
    output logic        o_done,
    output logic [31:0] o_sec,
    output logic [19:0] o_usec
);
    typedef enum logic [3:0] {
        DV_IDLE = 4'b0001,
        DV_Q1   = 4'b0010,
        DV_MUL  = 4'b0100,
        DV_Q2   = 4'b1000
    } t_dv_state;

    t_dv_state   r_state, n_state;
    logic [31:0] r_rate;
    logic [31:0] r_rem;
    logic [31:0] r_sh;
    logic [4:0]  r_cnt;
    logic [31:0] r_sec;
    logic [19:0] r_usec;
    logic [32:0] trial;
    logic        fits;
    logic [51:0] prod;

    always_comb begin
        trial = {r_rem, r_sh[31]};
        fits  = trial >= {1'b0, r_rate};
        prod  = {20'b0, r_rem} * {32'b0, USEC_PER_SEC};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            DV_IDLE: if (i_start && i_rate != 32'd0) n_state = DV_Q1;
            DV_Q1:   if (r_cnt == 5'd31) n_state = DV_MUL;
            DV_MUL:  n_state = DV_Q2;
            DV_Q2:   if (r_cnt == 5'd19) n_state = DV_IDLE;
            default: n_state = DV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            DV_IDLE: begin
                if (i_start) begin
                    r_rate <= i_rate;
                    r_rem  <= '0;
                    r_sh   <= i_ts;
                    r_cnt  <= '0;
                    r_sec  <= '0;
                    r_usec <= '0;
                end
            end
            DV_Q1, DV_Q2: begin
                r_rem <= fits ? (trial[31:0] - r_rate) : trial[31:0];
                r_sh  <= {r_sh[30:0], fits};
                r_cnt <= (r_state == DV_Q2 && r_cnt == 5'd19) ? 5'd0 : r_cnt + 5'd1;
                if (r_state == DV_Q2 && r_cnt == 5'd19) begin
                    r_usec <= {r_sh[18:0], fits};
                end
            end
            DV_MUL: begin
                // quotient of the first pass is complete here
                r_sec <= r_sh;
                r_rem <= prod[51:20];
                r_sh  <= {prod[19:0], 12'b0};
                r_cnt <= '0;
            end
            default: ;
        endcase
    end

    assign o_done = (r_state == DV_IDLE);
    assign o_sec  = r_sec;
    assign o_usec = r_usec;
endmodule

### sv/rhd_dp.sv
// Datapath: stream state, configuration registers, result register, divider.
// Uses rhd_pkg, rhd_if interfaces and rhd_div; driven by rhd_ctrl commands.
module rhd_dp
    import rhd_pkg::*;
#(
    parameter int LENGTH_BITS = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rhd_in_if.sink     i_in,
    rhd_out_if.source  o_out,
    rhd_cfg_if.sink    i_cfg,
    input  t_cmd       i_cmd,
    output t_status    o_status
);
    localparam logic [LENGTH_BITS-1:0] LenMax = '1;

    // configuration
    logic [6:0]  r_apt, r_vpt;
    logic        r_aen, r_ven;
    logic [31:0] r_arate, r_vrate;

    // stream state, index 0 audio, 1 video
    logic [31:0]            r_hts [2];
    logic                   r_act [2];
    logic [LENGTH_BITS-1:0] r_cnt [2];
    logic                   r_key;
    logic [1:0]             r_cls;
    logic [1:0]             r_pos;
    logic [7:0]             r_ind;

    // per-item results
    t_plan                  r_plan;
    logic [7:0]             r_byte;
    logic                   r_vid;
    logic [LENGTH_BITS-1:0] r_end_len;
    logic                   r_end_key;

    // output register
    logic        r_ovalid;
    logic [1:0]  r_kind;
    logic [7:0]  r_obyte;
    logic        r_ovid;
    logic        r_okey;
    logic [23:0] r_olen;
    logic [31:0] r_osec;
    logic [19:0] r_ousec;

    logic                   vid, aud, s;
    logic                   abort, fresh;
    logic [LENGTH_BITS-1:0] cnt0, cnt_new;
    logic [LENGTH_BITS:0]   sum;
    logic                   key_new;
    logic [31:0]            held;
    logic [1:0]             pos, cls_new, pos_new;
    logic [7:0]             ind_new, byte_new;
    logic                   sc, byte_en, fin;
    logic [4:0]             ntype, futype;
    logic [2:0]             nb;
    logic [LENGTH_BITS+23:0] len_ext;
    logic                   div_done;
    logic [31:0]            div_sec;
    logic [19:0]            div_usec;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_apt   <= 7'd97;
            r_vpt   <= 7'd96;
            r_aen   <= 1'b1;
            r_ven   <= 1'b1;
            r_arate <= 32'd8000;
            r_vrate <= 32'd90000;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_AUDIO_PT:   r_apt   <= i_cfg.data[6:0];
                REG_VIDEO_PT:   r_vpt   <= i_cfg.data[6:0];
                REG_AUDIO_EN:   r_aen   <= i_cfg.data[0];
                REG_VIDEO_EN:   r_ven   <= i_cfg.data[0];
                REG_AUDIO_RATE: r_arate <= i_cfg.data;
                REG_VIDEO_RATE: r_vrate <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        vid    = r_ven && (i_in.payload_type == r_vpt);
        aud    = !vid && r_aen && (i_in.payload_type == r_apt);
        s      = vid;
        abort  = r_act[s] && (r_hts[s] != i_in.rtp_timestamp);
        fresh  = abort || !r_act[s];
        held   = fresh ? i_in.rtp_timestamp : r_hts[s];
        cnt0   = abort ? '0 : r_cnt[s];
        key_new = abort ? 1'b0 : r_key;
        pos    = i_in.pkt_first ? 2'd0 : r_pos;
        ntype  = i_in.data_byte[4:0] & NAL_TYPE_MASK;
        futype = i_in.data_byte[4:0];
        cls_new = r_cls;
        ind_new = r_ind;
        sc      = 1'b0;
        byte_en = 1'b0;
        byte_new = i_in.data_byte;
        if (!vid) begin
            byte_en = 1'b1;
        end else if (pos == 2'd0) begin
            if (ntype == NAL_SLICE || is_key_type(ntype)) begin
                sc      = 1'b1;
                byte_en = 1'b1;
                cls_new = CLS_PASS;
                if (is_key_type(ntype)) key_new = 1'b1;
            end else if (ntype == NAL_FU_A) begin
                ind_new = i_in.data_byte;
                cls_new = CLS_FU_HDR;
            end else begin
                cls_new = CLS_DROP;
            end
        end else if (r_cls == CLS_FU_HDR) begin
            if (i_in.data_byte[7]) begin
                sc       = 1'b1;
                byte_en  = 1'b1;
                byte_new = (r_ind & FU_NRI_MASK) | {3'b0, futype};
                if (is_key_type(futype)) key_new = 1'b1;
            end
            cls_new = CLS_PASS;
        end else if (r_cls == CLS_PASS) begin
            byte_en = 1'b1;
        end
        pos_new = (pos < 2'd2) ? pos + 2'd1 : 2'd2;
        nb      = sc ? 3'd5 : {2'b0, byte_en};
        sum     = {1'b0, cnt0} + {{(LENGTH_BITS-2){1'b0}}, nb};
        cnt_new = sum[LENGTH_BITS] ? LenMax : sum[LENGTH_BITS-1:0];
        fin     = i_in.pkt_last && i_in.marker;
        len_ext = {24'b0, r_end_len};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act[0] <= 1'b0;
            r_act[1] <= 1'b0;
            r_hts[0] <= '0;
            r_hts[1] <= '0;
            r_cnt[0] <= '0;
            r_cnt[1] <= '0;
            r_key    <= 1'b0;
            r_cls    <= CLS_DROP;
            r_pos    <= 2'd0;
            r_ind    <= 8'd0;
            r_plan   <= '0;
        end else if (i_cmd.accept) begin
            r_plan <= '0;
            if (!vid && !aud) begin
                r_plan.unk <= i_in.pkt_first;
            end else begin
                r_plan.abort   <= abort;
                r_plan.sc      <= sc;
                r_plan.byte_en <= byte_en;
                r_plan.fin     <= fin;
                r_hts[s]       <= held;
                r_act[s]       <= !fin;
                r_cnt[s]       <= fin ? '0 : cnt_new;
                if (vid) begin
                    r_key <= fin ? 1'b0 : key_new;
                    r_cls <= cls_new;
                    r_pos <= pos_new;
                    r_ind <= ind_new;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte    <= byte_new;
            r_vid     <= vid;
            r_end_len <= cnt_new;
            r_end_key <= vid && key_new;
        end
    end

    rhd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.accept && (vid || aud) && fin),
        .i_ts    (held),
        .i_rate  (vid ? r_vrate : r_arate),
        .o_done  (div_done),
        .o_sec   (div_sec),
        .o_usec  (div_usec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_obyte <= 8'd0;
            r_ovid  <= r_vid;
            r_okey  <= 1'b0;
            r_olen  <= 24'd0;
            r_osec  <= 32'd0;
            r_ousec <= 20'd0;
            unique case (i_cmd.sel)
                SEL_UNK: begin
                    r_kind <= KIND_UNKNOWN;
                    r_ovid <= 1'b0;
                end
                SEL_ABORT: r_kind <= KIND_ABORT;
                SEL_SC: begin
                    r_kind  <= KIND_DATA;
                    r_obyte <= (i_cmd.sc_idx == 2'd3) ? 8'd1 : 8'd0;
                end
                SEL_BYTE: begin
                    r_kind  <= KIND_DATA;
                    r_obyte <= r_byte;
                end
                SEL_END: begin
                    r_kind  <= KIND_END;
                    r_okey  <= r_end_key;
                    r_olen  <= len_ext[23:0];
                    r_osec  <= div_sec;
                    r_ousec <= div_usec;
                end
                default: r_kind <= KIND_UNKNOWN;
            endcase
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.result_kind  = r_kind;
    assign o_out.out_byte     = r_obyte;
    assign o_out.is_video     = r_ovid;
    assign o_out.is_key       = r_okey;
    assign o_out.frame_length = r_olen;
    assign o_out.stamp_sec    = r_osec;
    assign o_out.stamp_usec   = r_ousec;

    always_comb begin
        o_status.plan     = r_plan;
        o_status.out_free = !r_ovalid || o_out.ready;
        o_status.div_done = div_done;
    end
endmodule

### sv/rhd_ctrl.sv
// Controller: steps through the results of one accepted byte.
// Uses rhd_pkg; talks to rhd_dp through t_cmd / t_status only.
module rhd_ctrl
    import rhd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PLAN  = 7'b0000010,
        ST_UNK   = 7'b0000100,
        ST_ABORT = 7'b0001000,
        ST_SC    = 7'b0010000,
        ST_BYTE  = 7'b0100000,
        ST_END   = 7'b1000000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_sc, n_sc;
    t_state     after_abort, after_byte;
    t_plan      plan;

    always_comb begin
        plan        = i_status.plan;
        after_byte  = plan.fin ? ST_END : ST_IDLE;
        after_abort = plan.sc ? ST_SC : (plan.byte_en ? ST_BYTE : after_byte);

        n_state      = r_state;
        n_sc         = r_sc;
        o_in_ready   = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.emit   = 1'b0;
        o_cmd.sel    = SEL_BYTE;
        o_cmd.sc_idx = r_sc;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) n_state = ST_PLAN;
            end
            ST_PLAN: begin
                n_sc    = 2'd0;
                n_state = plan.unk ? ST_UNK : (plan.abort ? ST_ABORT : after_abort);
            end
            ST_UNK: begin
                o_cmd.sel = SEL_UNK;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_ABORT: begin
                o_cmd.sel = SEL_ABORT;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = after_abort;
                end
            end
            ST_SC: begin
                o_cmd.sel = SEL_SC;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_sc       = r_sc + 2'd1;
                    if (r_sc == 2'd3) n_state = ST_BYTE;
                end
            end
            ST_BYTE: begin
                o_cmd.sel = SEL_BYTE;
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = after_byte;
                end
            end
            ST_END: begin
                o_cmd.sel = SEL_END;
                if (i_status.out_free && i_status.div_done) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sc    <= 2'd0;
        end else begin
            r_state <= n_state;
            r_sc    <= n_sc;
        end
    end
endmodule

### sv/rtp_h264_depacketizer.sv
// Top level of the RTP H.264 depacketizer; joins controller and datapath.
// Uses rhd_pkg, rhd_if, rhd_ctrl, rhd_dp.
//
// One payload byte is taken per item. An item occupies the block for an accept
// step, a plan step and one emit per result, of which there are 0 to 7: a plain
// pass-through byte gives one result, a NAL start with its start code five. A
// byte carrying the marker on the last byte of a packet also waits for the
// timestamp conversion, a shared bit-serial divider (32-bit quotient pass,
// multiply step and 20-bit quotient pass from accept), with no wait for a zero clock
// rate. Results leave through a registered output; the
// controller keeps stepping while a result waits as long as the register
// frees up. Register writes are taken any cycle and must be made while idle.
module rtp_h264_depacketizer
    import rhd_pkg::*;
#(
    parameter int LENGTH_BITS = 24
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rhd_in_if.sink    i_in,
    rhd_out_if.source o_out,
    rhd_cfg_if.sink   i_cfg
);
    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    assign i_in.ready = in_ready;

    rhd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rhd_dp #(.LENGTH_BITS(LENGTH_BITS)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_out    (o_out),
        .i_cfg    (i_cfg),
        .i_cmd    (cmd),
        .o_status (status)
    );
endmodule

### sv/rhd_checker.sv
// Port-level checks of the depacketizer, bound to its top level.
// Uses rhd_pkg for result codes.
module rhd_checker
    import rhd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  kind,
    input logic        is_video,
    input logic [23:0] frame_length,
    input logic [31:0] ts_sec
);
    // a stalled result stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // each accepted byte is worked on before the next one
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    a_unk_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && kind == KIND_UNKNOWN |-> !is_video)
        else $error("unknown type tagged as video");

    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && kind == KIND_DATA |-> frame_length == 24'd0 && ts_sec == 32'd0)
        else $error("data beat carries frame-end fields");
endmodule

bind rtp_h264_depacketizer rhd_checker u_rhd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .in_valid     (i_in.valid),
    .in_ready     (i_in.ready),
    .out_valid    (o_out.valid),
    .out_ready    (o_out.ready),
    .kind         (o_out.result_kind),
    .is_video     (o_out.is_video),
    .frame_length (o_out.frame_length),
    .ts_sec       (o_out.stamp_sec)
);

### dv/tb_top.sv
// Self-checking testbench of rtp_h264_depacketizer: directed table, then random
// packet streams, with a predictor, an expected-result queue and random stalls.
// Depends on rhd_pkg, rhd_if and the RTL of the block.
module tb_top;
    import rhd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [6:0]  pt;
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic        mark;
        logic [31:0] ts;
    } t_beat;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic        vid;
        logic        key;
        logic [23:0] len;
        logic [31:0] sec;
        logic [19:0] usec;
    } t_res;

    typedef struct {
        t_beat b;
        bit    has_res;
        t_res  r;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rhd_in_if  in_if();
    rhd_out_if out_if();
    rhd_cfg_if cfg_if();

    rtp_h264_depacketizer u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if.sink),
        .o_out  (out_if.source),
        .i_cfg  (cfg_if.sink)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state and configuration copy
    logic [6:0]  m_apt, m_vpt;
    logic        m_aen, m_ven;
    logic [31:0] m_arate, m_vrate;
    logic [31:0] m_held [2];
    logic        m_active [2];
    logic [23:0] m_count [2];
    logic        m_key;
    logic [1:0]  m_class;
    logic [1:0]  m_pos;
    logic [7:0]  m_ind;

    t_res expected_q[$];
    int   fails = 0;
    bit   hold_off = 0;
    bit   stalls_on = 1;

    function automatic t_res mk(logic [1:0] k, logic [7:0] d, logic v, logic key,
                                logic [23:0] l, logic [31:0] s, logic [19:0] u);
        t_res r;
        r.kind = k; r.data = d; r.vid = v; r.key = key; r.len = l; r.sec = s; r.usec = u;
        return r;
    endfunction

    function automatic bit key_nal(logic [4:0] t);
        return t == NAL_IDR || t == NAL_SPS || t == NAL_PPS;
    endfunction

    task automatic push_byte(int s, logic [7:0] d);
        expected_q.push_back(mk(KIND_DATA, d, s[0], 1'b0, 24'd0, 32'd0, 20'd0));
        if (m_count[s] != 24'hFFFFFF) m_count[s]++;
    endtask

    task automatic push_nal(logic [7:0] hdr);
        for (int i = 0; i < 3; i++) push_byte(1, 8'h00);
        push_byte(1, 8'h01);
        push_byte(1, hdr);
    endtask

    task automatic end_frame(int s);
        m_active[s] = 0;
        m_count[s] = 0;
        if (s == 1) m_key = 0;
    endtask

    task automatic predict_beat(t_beat b);
        int s;
        logic [1:0] pos;
        logic [31:0] rate, sec;
        logic [63:0] us;
        if (m_ven && b.pt == m_vpt) s = 1;
        else if (m_aen && b.pt == m_apt) s = 0;
        else begin
            if (b.first) expected_q.push_back(mk(KIND_UNKNOWN, 0, 0, 0, 0, 0, 0));
            return;
        end
        if (m_active[s] && m_held[s] != b.ts) begin
            expected_q.push_back(mk(KIND_ABORT, 0, s[0], 0, 0, 0, 0));
            end_frame(s);
        end
        if (!m_active[s]) begin
            m_held[s] = b.ts;
            m_active[s] = 1;
        end
        if (s == 0) begin
            push_byte(0, b.data);
        end else begin
            pos = b.first ? 2'd0 : m_pos;
            if (pos == 0) begin
                if (b.data[4:0] == NAL_SLICE || key_nal(b.data[4:0])) begin
                    push_nal(b.data);
                    if (key_nal(b.data[4:0])) m_key = 1;
                    m_class = CLS_PASS;
                end else if (b.data[4:0] == NAL_FU_A) begin
                    m_ind = b.data;
                    m_class = CLS_FU_HDR;
                end else begin
                    m_class = CLS_DROP;
                end
            end else if (m_class == CLS_FU_HDR) begin
                if (b.data[7]) begin
                    push_nal((m_ind & FU_NRI_MASK) | {3'b000, b.data[4:0]});
                    if (key_nal(b.data[4:0])) m_key = 1;
                end
                m_class = CLS_PASS;
            end else if (m_class == CLS_PASS) begin
                push_byte(1, b.data);
            end
            m_pos = pos < 2 ? pos + 2'd1 : 2'd2;
        end
        if (b.last && b.mark) begin
            rate = s ? m_vrate : m_arate;
            sec = 0;
            us = 0;
            if (rate != 0) begin
                sec = m_held[s] / rate;
                us = ((64'(m_held[s]) * 64'd1000000) / rate) % 64'd1000000;
            end
            expected_q.push_back(mk(KIND_END, 0, s[0], s ? m_key : 1'b0, m_count[s],
                                    sec, us[19:0]));
            end_frame(s);
        end
    endtask

    task automatic reset_model();
        m_apt = 97; m_vpt = 96; m_aen = 1; m_ven = 1; m_arate = 8000; m_vrate = 90000;
        for (int s = 0; s < 2; s++) begin
            m_held[s] = 0; m_active[s] = 0; m_count[s] = 0;
        end
        m_key = 0; m_class = CLS_DROP; m_pos = 0; m_ind = 0;
    endtask

    task automatic idle_gap();
        int r;
        if (!stalls_on) return;
        r = $urandom_range(0, 99);
        if (r < 60) return;
        repeat (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(negedge i_clk);
    endtask

    // valid drops at the negedge after accept; the next beat raises it after an optional random gap
    task automatic send_beat(t_beat b);
        @(negedge i_clk);
        idle_gap();
        in_if.valid <= 1'b1;
        in_if.payload_type <= b.pt;
        in_if.data_byte <= b.data;
        in_if.pkt_first <= b.first;
        in_if.pkt_last <= b.last;
        in_if.marker <= b.mark;
        in_if.rtp_timestamp <= b.ts;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_beat(b);
        @(negedge i_clk);
        in_if.valid <= 1'b0;
    endtask

    task automatic drain();
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            REG_AUDIO_PT:   m_apt = val[6:0];
            REG_VIDEO_PT:   m_vpt = val[6:0];
            REG_AUDIO_EN:   m_aen = val[0];
            REG_VIDEO_EN:   m_ven = val[0];
            REG_AUDIO_RATE: m_arate = val;
            REG_VIDEO_RATE: m_vrate = val;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic t_beat bt(logic [6:0] pt, logic [7:0] d, logic f, logic l, logic m,
                                 logic [31:0] ts);
        t_beat b;
        b.pt = pt; b.data = d; b.first = f; b.last = l; b.mark = m; b.ts = ts;
        return b;
    endfunction

    // one random packet: mostly well formed NAL or FU-A, some noise
    task automatic send_packet(logic [6:0] pt, logic [31:0] ts, bit mark);
        int n, kind;
        logic [7:0] d;
        n = $urandom_range(0, 9) == 0 ? 1 : $urandom_range(2, 6);
        kind = $urandom_range(0, 9);
        for (int i = 0; i < n; i++) begin
            d = $urandom;
            if (i == 0) begin
                case (kind)
                    0, 1, 2: d[4:0] = NAL_FU_A;
                    3:       d[4:0] = NAL_SLICE;
                    4:       d[4:0] = NAL_IDR;
                    5:       d[4:0] = NAL_SPS;
                    6:       d[4:0] = NAL_PPS;
                    default: ;
                endcase
            end
            send_beat(bt(pt, d, i == 0 || $urandom_range(0, 30) == 0, i == n - 1,
                         (i == n - 1) ? mark : $urandom_range(0, 1), ts));
        end
    endtask

    t_row dir_tab[$];

    task automatic add_row(t_beat b, bit h, t_res r);
        t_row w;
        w.b = b; w.has_res = h; w.r = r;
        dir_tab.push_back(w);
    endtask

    // output side: random stall, sample at rising edge
    initial begin
        t_res e, a;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) out_if.ready <= 1'b0;
            else if (!stalls_on) out_if.ready <= 1'b1;
            else out_if.ready <= ($urandom_range(0, 99) < 70) ||
                                 ($urandom_range(0, 99) < 3 ? 1'b0 : 1'b0);
            @(posedge i_clk);
            if (out_if.valid && out_if.ready) begin
                a = mk(out_if.result_kind, out_if.out_byte, out_if.is_video, out_if.is_key,
                       out_if.frame_length, out_if.stamp_sec, out_if.stamp_usec);
                if (expected_q.size() == 0) begin
                    $error("unexpected result kind %0d", a.kind);
                    fails++;
                end else begin
                    e = expected_q.pop_front();
                    if (e.kind != a.kind) begin
                        $error("result_kind exp %0d got %0d", e.kind, a.kind); fails++;
                    end
                    if (e.data != a.data) begin
                        $error("out_byte exp %0h got %0h", e.data, a.data); fails++;
                    end
                    if (e.vid != a.vid) begin
                        $error("is_video exp %0d got %0d", e.vid, a.vid); fails++;
                    end
                    if (e.key != a.key) begin
                        $error("is_key exp %0d got %0d", e.key, a.key); fails++;
                    end
                    if (e.len != a.len) begin
                        $error("frame_length exp %0d got %0d", e.len, a.len); fails++;
                    end
                    if (e.sec != a.sec) begin
                        $error("stamp_sec exp %0d got %0d", e.sec, a.sec); fails++;
                    end
                    if (e.usec != a.usec) begin
                        $error("stamp_usec exp %0d got %0d", e.usec, a.usec); fails++;
                    end
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        logic [31:0] ts;
        logic [6:0] pt;
        t_res z;
        int sent;
        z = mk(0, 0, 0, 0, 0, 0, 0);
        in_if.valid = 0; in_if.payload_type = 0; in_if.data_byte = 0; in_if.pkt_first = 0;
        in_if.pkt_last = 0; in_if.marker = 0; in_if.rtp_timestamp = 0;
        cfg_if.valid = 0; cfg_if.index = 0; cfg_if.data = 0;
        reset_model();
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: unknown type, byte without start after reset, audio, NALs, FU-A
        add_row(bt(7'd0, 8'h00, 1, 1, 1, 0), 1, mk(KIND_UNKNOWN, 0, 0, 0, 0, 0, 0));
        add_row(bt(7'd127, 8'hFF, 0, 0, 0, 0), 0, z);
        add_row(bt(7'd97, 8'hFF, 1, 1, 1, 32'd8000), 0, z);
        add_row(bt(7'd97, 8'h00, 1, 1, 1, 32'hFFFFFFFF), 0, z);
        add_row(bt(7'd96, 8'h65, 0, 0, 0, 32'd90000), 0, z);
        add_row(bt(7'd96, 8'hAA, 0, 1, 1, 32'd90000), 0, z);
        add_row(bt(7'd96, 8'h67, 1, 0, 0, 32'd5), 0, z);
        add_row(bt(7'd96, 8'h12, 0, 0, 1, 32'd5), 0, z);
        add_row(bt(7'd96, 8'h68, 1, 1, 0, 32'd6), 0, z);
        add_row(bt(7'd96, 8'h7C, 1, 0, 0, 32'd6), 0, z);
        add_row(bt(7'd96, 8'h85, 0, 0, 0, 32'd6), 0, z);
        add_row(bt(7'd96, 8'h33, 0, 1, 0, 32'd6), 0, z);
        add_row(bt(7'd96, 8'h5C, 1, 0, 0, 32'd6), 0, z);
        add_row(bt(7'd96, 8'h41, 0, 0, 0, 32'd6), 0, z);
        add_row(bt(7'd96, 8'h44, 0, 1, 1, 32'd6), 0, z);
        add_row(bt(7'd96, 8'hFC, 1, 1, 1, 32'd7), 0, z);
        add_row(bt(7'd96, 8'h06, 1, 1, 1, 32'd7), 0, z);
        add_row(bt(7'd96, 8'h01, 1, 1, 1, 32'hFFFFFFFF), 0, z);
        foreach (dir_tab[i]) begin
            if (dir_tab[i].has_res) begin
                send_beat(dir_tab[i].b);
                if (expected_q.size() != 1 || expected_q[0] != dir_tab[i].r) begin
                    $error("directed row %0d table mismatch", i);
                    fails++;
                end
            end else begin
                send_beat(dir_tab[i].b);
            end
        end
        drain();

        // equal types, zero and extreme rates
        write_reg(REG_AUDIO_PT, 32'd96);
        write_reg(REG_VIDEO_RATE, 32'd0);
        write_reg(REG_AUDIO_RATE, 32'hFFFFFFFF);
        send_beat(bt(7'd96, 8'h65, 1, 1, 1, 32'd1234));
        drain();
        write_reg(REG_VIDEO_EN, 32'd0);
        send_beat(bt(7'd96, 8'h21, 1, 1, 1, 32'hFFFFFFFF));
        drain();

        sent = 0;
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_AUDIO_PT, ph == 3 ? 32'd127 : $urandom_range(0, 127));
            write_reg(REG_VIDEO_PT, ph == 2 ? 32'd0 : $urandom_range(0, 127));
            write_reg(REG_AUDIO_EN, ph != 1);
            write_reg(REG_VIDEO_EN, 32'd1);
            write_reg(REG_AUDIO_RATE, ph == 0 ? 32'd1 : $urandom);
            write_reg(REG_VIDEO_RATE, ph == 3 ? 32'hFFFFFFFF : $urandom_range(1, 200000));
            if (ph == 1) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (300) @(negedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            if (ph == 3) stalls_on = 0;
            for (int k = 0; k < 20; k++) begin
                ts = $urandom_range(0, 3) == 0 ? $urandom : 32'(k / 3);
                case ($urandom_range(0, 9))
                    0: pt = $urandom;
                    1, 2: pt = m_apt;
                    default: pt = m_vpt;
                endcase
                if (pt == m_apt && $urandom_range(0, 1)) begin
                    send_beat(bt(pt, $urandom, 1, 1, $urandom_range(0, 1), ts));
                    sent++;
                end else begin
                    send_packet(pt, ts, $urandom_range(0, 2) == 0);
                    sent += 4;
                end
            end
            stalls_on = 1;
            drain();
        end
        write_reg(REG_AUDIO_PT, 32'd97);
        write_reg(REG_VIDEO_PT, 32'd96);
        write_reg(REG_AUDIO_RATE, 32'd8000);
        write_reg(REG_VIDEO_RATE, 32'd90000);
        write_reg(REG_AUDIO_EN, 32'd1);
        while (sent < 330) begin
            send_packet($urandom_range(0, 3) == 0 ? 7'd97 : 7'd96,
                        32'($urandom_range(0, 4)), $urandom_range(0, 1));
            sent += 4;
        end
        drain();
        if (fails == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule

### rtp_h264_depacketizer.f
sv/rhd_pkg.sv
sv/rhd_if.sv
sv/rhd_div.sv
sv/rhd_dp.sv
sv/rhd_ctrl.sv
sv/rtp_h264_depacketizer.sv
sv/rhd_checker.sv
dv/tb_top.sv
